/* sv/sitr_pkg.sv */
// types, constants and the reciprocal table for signed_integer_to_radix_text
// no dependencies; imported by the top level
package sitr_pkg;

  localparam int unsigned MaxRadix  = 16;
  localparam int unsigned MaxDigits = 32;

  localparam int unsigned ValueW = 32;
  localparam int unsigned SymW   = 8;
  localparam int unsigned RadixW = 5;
  localparam int unsigned CountW = $clog2(MaxDigits + 1);
  localparam int unsigned DigitW = $clog2(MaxRadix);
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 64;

  localparam logic [SymW-1:0] PlusSymbol  = 8'h2B;
  localparam logic [SymW-1:0] MinusSymbol = 8'h2D;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    RegRadix   = 2'd0,
    RegSymLow  = 2'd1,
    RegSymHigh = 2'd2,
    RegNone    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StMul  = 2'd1,
    StFix  = 2'd2,
    StEmit = 2'd3
  } state_e;

  // floor(2^32 / radix); quotient estimate is at most one below the true one
  function automatic logic [ValueW-1:0] recip_of(input logic [RadixW-1:0] radix);
    logic [ValueW-1:0] r;
    unique case (radix)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/signed_integer_to_radix_text.sv */
// signed 32-bit integer to text in a configurable radix, stream in and out
// depends on sitr_pkg
//
// Each input item is one signed 32-bit value; the block sends its text one
// character per output item, most significant digit first, with a leading
// minus symbol for negative values (the most negative value prints
// correctly). Radix and up to 16 digit symbols are set over the APB port:
// radix_size at 0x00, symbols 0..7 at 0x08, symbols 8..15 at 0x10, one
// byte per symbol, lowest byte first. A radix outside 2..16, a repeated
// symbol or a '+' or '-' symbol gives a single item with tuser (error) and
// tlast set instead of text. Digits come from one shared 32x32 multiplier
// against a reciprocal table: each digit is a multiply step, then a
// remainder correction step. Once all digits are found, the characters
// leave at one per cycle while the output is not held by tready low.
// Input is not ready while an item is being worked on.
module signed_integer_to_radix_text (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [sitr_pkg::ValueW-1:0] s_axis_tdata_i,   // [31:0] value
  // output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [sitr_pkg::SymW-1:0]   m_axis_tdata_o,   // [7:0] symbol
  output logic                        m_axis_tlast_o,
  output logic                        m_axis_tuser_o,   // [0] error
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sitr_pkg::AddrW-1:0]  paddr,
  input  logic [sitr_pkg::DataW-1:0]  pwdata,
  output logic [sitr_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import sitr_pkg::*;

  // configuration registers
  logic [RadixW-1:0] radix_q;
  logic [DataW-1:0]  sym_lo_q, sym_hi_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  // sequencer and datapath
  state_e            state_q, state_d;
  logic              neg_q, neg_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0] quo_q, quo_d;
  logic [ValueW-1:0] qest_q;
  logic [2*ValueW-1:0] full_prod;
  logic [11:0]       back_prod;
  logic [5:0]        rem_est;
  logic [5:0]        rem_fix;
  logic [ValueW-1:0] quo_fix;
  logic              store_we;
  logic [DigitW-1:0] store_q [MaxDigits];
  logic [$clog2(MaxDigits)-1:0] rd_idx;
  logic [DigitW-1:0] rd_digit_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [SymW-1:0]   out_sym_q, out_sym_d;
  logic              out_last_q, out_last_d;
  logic              out_err_q, out_err_d;
  logic              out_load;
  logic              out_free;
  logic              in_acc;

  // symbol set check
  logic [SymW-1:0]   syms [MaxRadix];
  logic              set_valid;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= '0;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegRadix:   radix_q  <= pwdata[RadixW-1:0];
        RegSymLow:  sym_lo_q <= pwdata;
        RegSymHigh: sym_hi_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      RegRadix:   prdata = DataW'(radix_q);
      RegSymLow:  prdata = sym_lo_q;
      RegSymHigh: prdata = sym_hi_q;
      default:    prdata = '0;
    endcase
  end

  // symbol set check over all pairs in use
  always_comb begin
    for (int i = 0; i < MaxRadix; i++) begin
      syms[i] = (i < 8) ? sym_lo_q[8*(i%8) +: 8] : sym_hi_q[8*(i%8) +: 8];
    end
    set_valid = (radix_q >= RadixW'(2)) && (radix_q <= RadixW'(MaxRadix));
    for (int i = 0; i < MaxRadix; i++) begin
      if (RadixW'(i) < radix_q) begin
        if (syms[i] == PlusSymbol || syms[i] == MinusSymbol) set_valid = 1'b0;
        for (int j = i + 1; j < MaxRadix; j++) begin
          if (RadixW'(j) < radix_q && syms[i] == syms[j]) set_valid = 1'b0;
        end
      end
    end
  end

  // shared multiplier and remainder correction
  assign full_prod = (2*ValueW)'(quo_q) * (2*ValueW)'(recip_of(radix_q));
  assign back_prod = qest_q[5:0] * {1'b0, radix_q};
  assign rem_est   = quo_q[5:0] - back_prod[5:0];
  always_comb begin
    if (rem_est >= {1'b0, radix_q}) begin
      rem_fix = rem_est - {1'b0, radix_q};
      quo_fix = qest_q + ValueW'(1);
    end else begin
      rem_fix = rem_est;
      quo_fix = qest_q;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && out_free;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  // address of the digit needed in the next cycle
  assign rd_idx   = cnt_d[$clog2(MaxDigits)-1:0] - 1'b1;

  // sequencer
  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    store_we    = 1'b0;
    out_load    = 1'b0;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (!set_valid) begin
            out_load   = 1'b1;
            out_sym_d  = '0;
            out_last_d = 1'b1;
            out_err_d  = 1'b1;
          end else begin
            neg_d   = s_axis_tdata_i[ValueW-1];
            quo_d   = s_axis_tdata_i[ValueW-1] ? ValueW'(0) - s_axis_tdata_i
                                               : s_axis_tdata_i;
            cnt_d   = '0;
            state_d = StMul;
          end
        end
      end
      StMul: begin
        state_d = StFix;
      end
      StFix: begin
        store_we = 1'b1;
        quo_d    = quo_fix;
        cnt_d    = cnt_q + 1'b1;
        if (quo_fix == '0 || cnt_d == CountW'(MaxDigits)) state_d = StEmit;
        else state_d = StMul;
      end
      StEmit: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_err_d = 1'b0;
          if (neg_q) begin
            neg_d      = 1'b0;
            out_sym_d  = MinusSymbol;
            out_last_d = 1'b0;
          end else begin
            out_sym_d  = syms[rd_digit_q];
            out_last_d = (cnt_q == CountW'(1));
            cnt_d      = cnt_q - 1'b1;
            if (cnt_q == CountW'(1)) state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (out_load) out_valid_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    qest_q     <= full_prod[2*ValueW-1:ValueW];
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  // digit buffer, least significant digit first
  // registered read; a digit written in the same cycle is passed straight on
  always_ff @(posedge clk_i) begin
    if (store_we) store_q[cnt_q[$clog2(MaxDigits)-1:0]] <= rem_fix[DigitW-1:0];
    rd_digit_q <= store_we ? rem_fix[DigitW-1:0] : store_q[rd_idx];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sym_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_err_q;

  // digit count never passes the buffer depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(MaxDigits))
    else $error("digit count beyond buffer depth");

  // an error item always closes its text
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_last_q)
    else $error("error item without last");

  // a bad symbol set answers at once with an error item
  a_err_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !set_valid |=> out_valid_q && out_err_q && state_q == StIdle)
    else $error("invalid set not reported");

  // emission always has something left to send
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> (cnt_q != '0 || neg_q))
    else $error("emit with empty buffer");

endmodule
